FILE: hdl/assert_macros.svh
// Assertion macros shared by the limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hdl/lbcl_pkg.sv
// Package with types, constants and helpers of the concurrency limiter.
`timescale 1ns / 1ps
package lbcl_pkg;
   localparam int SAMPLES          = 16;
   localparam int PERCENTILE_RANK  = 12;
   localparam int REFRACTORY_TICKS = 8;
   localparam int CW               = $clog2(SAMPLES + 1);
   localparam int RANK_SAT = (PERCENTILE_RANK > SAMPLES - 1) ? SAMPLES - 1 : PERCENTILE_RANK;
   localparam logic [19:0] MAX20 = 20'hFFFFF;

   localparam logic [2:0] REG_ENABLED  = 3'd0;
   localparam logic [2:0] REG_TARGET   = 3'd1;
   localparam logic [2:0] REG_DECREASE = 3'd2;
   localparam logic [2:0] REG_ADDITIVE = 3'd3;
   localparam logic [2:0] REG_DISTANCE = 3'd4;
   localparam logic [2:0] REG_LOWER    = 3'd5;
   localparam logic [2:0] REG_UPPER    = 3'd6;
   localparam logic [2:0] REG_FACTOR   = 3'd7;

   typedef struct packed {
      logic [6:0]  load_percent;
      logic [19:0] active_requests;
   } req_type;

   typedef struct packed {
      logic [19:0] request_limit;
      logic [19:0] stable_estimate;
      logic        overloaded;
      logic        estimate_ready;
   } rsp_type;

   // Control from sequencer to the rank cells.
   typedef struct packed {
      logic        load;       // shift a new sample into the chain
      logic [19:0] sample;
      logic        probe;      // compare broadcast candidate
      logic [19:0] cand;
   } cell_ctl_type;
endpackage

FILE: hdl/lbcl_cell.sv
// One cell of the sample chain: holds a sample, shifts it on, flags below/upto the candidate.
`timescale 1ns / 1ps
module lbcl_cell (
   input  logic                 clock,
   input  lbcl_pkg::cell_ctl_type ctl,
   input  logic [19:0]          prev_value,
   output logic [19:0]          value,
   output logic                 is_below,
   output logic                 is_upto
);
   import lbcl_pkg::*;
   logic [19:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = prev_value;
      end else if (ctl.probe) begin
         value_in = prev_value; // rotate so every sample passes as candidate
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign is_below = value_ff < ctl.cand;
   assign is_upto  = value_ff <= ctl.cand;
endmodule

FILE: hdl/lbcl_divider.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lbcl_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [42:0] dividend,
   input  logic [14:0] divisor,
   output logic        done,
   output logic [42:0] quotient
);
   import lbcl_pkg::*;
   logic [42:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [14:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [15:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; div_in = div_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[14:0], quo_ff[42]};
      if (start) begin
         quo_in = dividend; rem_in = '0; div_in = divisor;
         cnt_in = 6'd43; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[41:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[41:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: hdl/load_based_concurrency_limiter.sv
// Top level of the load based concurrency limiter.
`timescale 1ns / 1ps
// Load based concurrency limiter (limit controller with multiplicative increase and decrease).
// Input channel req_*: one item per control tick, carrying load percent and
// active request count. Result channel rsp_*: one item per tick with the new
// limit, the stable estimate and the overloaded and estimate_ready flags.
// Configuration through the csr_ APB port, registers at byte address 4*i;
// write only while idle.
// From accept to result valid, a disabled tick or a calm tick with zero load
// or zero active goes from ST_IDLE straight to ST_OUT; an overloaded tick runs
// ST_MUL1, ST_MUL2, ST_DECIDE and ST_OUT, and a calm tick that only applies
// the growth rule adds ST_GROW before ST_OUT. A sampling tick runs the 43-step
// serial divider; the tick that fills the store also runs the percentile pass
// through the cell chain, one candidate a cycle until each sample was probed.
// One tick is in work at a time; the next item can be accepted in the same
// cycle in which the result of the previous one turns valid. The result
// register holds a finished item while rsp_stall is high; a following tick
// that finishes meanwhile waits in its last state until the register is free.
// Reset (synchronous, active high) restores register defaults, the limit to
// the upper bound, the refractory timer to full, and empties the store.
module load_based_concurrency_limiter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lbcl_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lbcl_pkg::rsp_type     rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import lbcl_pkg::*;
   `include "assert_macros.svh"

   localparam logic [3:0] ST_IDLE = 4'd0, ST_MUL1 = 4'd1, ST_MUL2 = 4'd2,
      ST_DECIDE = 4'd3, ST_DIV = 4'd4, ST_WAITDIV = 4'd5, ST_SEL = 4'd6,
      ST_GROW = 4'd7, ST_OUT = 4'd8;

   // configuration registers
   logic        enabled_ff;
   logic [6:0]  target_ff;
   logic [15:0] dec_ff, add_ff, dist_ff, factor_ff;
   logic [19:0] lower_ff, upper_ff;
   logic        wr;
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0; target_ff <= 7'd90; dec_ff <= 16'd3277;
         add_ff <= 16'd3277; dist_ff <= 16'd3277; lower_ff <= 20'd1;
         upper_ff <= MAX20; factor_ff <= 16'd256;
      end else if (wr) begin
         unique case (csr_paddr[4:2])
            REG_ENABLED:  enabled_ff <= csr_pwdata[0];
            REG_TARGET:   target_ff  <= csr_pwdata[6:0];
            REG_DECREASE: dec_ff     <= csr_pwdata[15:0];
            REG_ADDITIVE: add_ff     <= csr_pwdata[15:0];
            REG_DISTANCE: dist_ff    <= csr_pwdata[15:0];
            REG_LOWER:    lower_ff   <= csr_pwdata[19:0];
            REG_UPPER:    upper_ff   <= csr_pwdata[19:0];
            REG_FACTOR:   factor_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ENABLED:  csr_prdata = {31'd0, enabled_ff};
         REG_TARGET:   csr_prdata = {25'd0, target_ff};
         REG_DECREASE: csr_prdata = {16'd0, dec_ff};
         REG_ADDITIVE: csr_prdata = {16'd0, add_ff};
         REG_DISTANCE: csr_prdata = {16'd0, dist_ff};
         REG_LOWER:    csr_prdata = {12'd0, lower_ff};
         REG_UPPER:    csr_prdata = {12'd0, upper_ff};
         REG_FACTOR:   csr_prdata = {16'd0, factor_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // tick state
   logic [3:0]  st_ff, st_in;
   logic [19:0] limit_ff, limit_in, est_ff, est_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]  tso_ff, tso_in;
   logic [6:0]  load_ff, load_in;
   logic [19:0] act_ff, act_in;
   logic [35:0] pa_ff, pa_in;       // limit*fraction
   logic [36:0] pb_ff, pb_in;       // distance test product
   logic [26:0] ac_ff, ac_in;       // active*target
   logic [42:0] num_ff, num_in;     // active*target*factor
   logic        over_ff, over_in;
   logic        rv_ff, rv_in;
   rsp_type     rd_ff, rd_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [19:0] best_ff, best_in;
   logic        found_ff, found_in;

   // divider
   logic        div_start, div_done;
   logic [42:0] div_q;
   lbcl_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(num_ff), .divisor({load_ff, 8'd0}),
      .done(div_done), .quotient(div_q)
   );

   // sample chain
   cell_ctl_type ctl;
   logic [19:0] vals [SAMPLES];
   logic [SAMPLES-1:0] below_v, upto_v;
   logic [19:0] sample_sat;
   assign sample_sat = (div_q > {23'd0, MAX20}) ? MAX20 : div_q[19:0];

   for (genvar g = 0; g < SAMPLES; g++) begin : g_cell
      logic [19:0] prev;
      if (g == 0) begin : g_head
         assign prev = ctl.load ? ctl.sample : vals[SAMPLES-1];
      end else begin : g_body
         assign prev = vals[g-1];
      end
      lbcl_cell u_cell (
         .clock(clock), .ctl(ctl), .prev_value(prev),
         .value(vals[g]), .is_below(below_v[g]), .is_upto(upto_v[g])
      );
   end

   // candidate is the tail of the chain, which rotates one place per probe
   logic [CW:0] nbelow, nupto;
   assign nbelow = ($bits(nbelow))'($countones(below_v));
   assign nupto  = ($bits(nupto))'($countones(upto_v));

   logic        acc;
   logic [16:0] dist_c;
   logic [20:0] grown;
   logic [19:0] dstep, astep;
   logic [20:0] dec_nl;
   assign acc = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE);
   assign dist_c = 17'd65536 - {1'b0, dist_ff};
   assign dstep = (pa_ff[35:16] == 20'd0) ? 20'd1 : pa_ff[35:16];
   assign astep = dstep;
   assign dec_nl = {1'b0, limit_ff} - {1'b0, dstep};
   assign grown  = {1'b0, limit_ff} + {1'b0, astep};

   always_comb begin
      st_in = st_ff; limit_in = limit_ff; est_in = est_ff; count_in = count_ff;
      tso_in = tso_ff; load_in = load_ff; act_in = act_ff; pa_in = pa_ff;
      pb_in = pb_ff; ac_in = ac_ff; num_in = num_ff; over_in = over_ff;
      rv_in = rv_ff; rd_in = rd_ff; idx_in = idx_ff; best_in = best_ff;
      found_in = found_ff; div_start = 1'b0;
      ctl = '{load: 1'b0, sample: sample_sat, probe: 1'b0, cand: vals[SAMPLES-1]};
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      unique case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               load_in = req_data.load_percent; act_in = req_data.active_requests;
               over_in = 1'b0;
               if (!enabled_ff) begin
                  st_in = ST_OUT;
               end else if (req_data.load_percent >= target_ff) begin
                  over_in = 1'b1; tso_in = '0; st_in = ST_MUL1;
               end else begin
                  if (tso_ff != 8'd255) begin
                     tso_in = tso_ff + 8'd1;
                  end
                  st_in = (req_data.active_requests == '0 || req_data.load_percent == '0)
                     ? ST_OUT : ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            pa_in = limit_ff * (over_ff ? dec_ff : add_ff);
            pb_in = dist_c * limit_ff;
            ac_in = act_ff * target_ff;
            st_in = ST_MUL2;
         end
         ST_MUL2: begin
            num_in = ac_ff * factor_ff;
            st_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (over_ff) begin
               limit_in = (dec_nl[20] || dec_nl[19:0] < lower_ff) ? lower_ff : dec_nl[19:0];
               st_in = ST_OUT;
            end else if ({24'd0, tso_ff} >= 32'(REFRACTORY_TICKS) &&
                         {{(32-CW){1'b0}}, count_ff} < 32'(SAMPLES)) begin
               div_start = 1'b1; st_in = ST_WAITDIV;
            end else begin
               st_in = ST_GROW;
            end
         end
         ST_WAITDIV: begin
            if (div_done) begin
               ctl.load = 1'b1;
               count_in = count_ff + 1'b1;
               if ({{(32-CW){1'b0}}, count_ff} == 32'(SAMPLES - 1)) begin
                  idx_in = '0; found_in = 1'b0; best_in = '0; st_in = ST_SEL;
               end else begin
                  st_in = ST_GROW;
               end
            end
         end
         ST_SEL: begin
            ctl.probe = 1'b1;
            if (!found_ff && {1'b0, nbelow} <= (CW + 2)'(RANK_SAT) &&
                (CW + 2)'(RANK_SAT) < {1'b0, nupto}) begin
               found_in = 1'b1; best_in = vals[SAMPLES-1];
            end
            idx_in = idx_ff + 1'b1;
            if ({{(32-CW){1'b0}}, idx_ff} == 32'(SAMPLES - 1)) begin
               st_in = ST_DIV;
            end
         end
         ST_DIV: begin // commit percentile
            est_in = best_ff; limit_in = best_ff; st_in = ST_OUT;
         end
         ST_GROW: begin
            if ({act_ff, 16'd0} >= {pb_ff[35:0]} && !pb_ff[36] ||
                {1'b0, act_ff, 16'd0} >= pb_ff) begin
               limit_in = (grown > {1'b0, upper_ff}) ? upper_ff : grown[19:0];
            end
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rd_in.request_limit   = limit_ff;
               rd_in.stable_estimate = est_ff;
               rd_in.overloaded      = over_ff;
               rd_in.estimate_ready  = {{(32-CW){1'b0}}, count_ff} >= 32'(SAMPLES);
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; limit_ff <= MAX20; est_ff <= '0; count_ff <= '0;
         tso_ff <= 8'(REFRACTORY_TICKS); rv_ff <= 1'b0; found_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         st_ff <= st_in; limit_ff <= limit_in; est_ff <= est_in; count_ff <= count_in;
         tso_ff <= tso_in; rv_ff <= rv_in; found_ff <= found_in; idx_ff <= idx_in;
      end
      load_ff <= load_in; act_ff <= act_in; pa_ff <= pa_in; pb_ff <= pb_in;
      ac_ff <= ac_in; num_ff <= num_in; over_ff <= over_in; rd_ff <= rd_in;
      best_ff <= best_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   `ASSERT_CLK(a_stall_when_busy, clock, reset, (st_ff != ST_IDLE) |-> req_stall, "busy but ready")
   `ASSERT_CLK(a_hold_result, clock, reset, (rv_ff && rsp_stall) |=> (rv_ff && $stable(rd_ff)), "result lost")
   `ASSERT_CLK(a_count_bound, clock, reset, {{(32-CW){1'b0}}, count_ff} <= 32'(SAMPLES), "count overflow")
endmodule
